[design/ncm_pkg.sv]
// ncm_pkg: shared types and constants for the nearest palette color match unit
// no dependencies; used by every module of the block except ncm_ram

package ncm_pkg;

  // slot fields address 16 x 16 entries
  localparam int SlotLimit    = 16;
  localparam int SlotW        = 4;
  localparam int TableDepth   = SlotLimit * SlotLimit;
  localparam int AddrW        = 2 * SlotW;
  localparam int EntryW       = 32;
  localparam int IndexW       = 5;
  localparam int DistW        = 18;
  localparam int DefMaxColors = 16;
  localparam int DefMaxShades = 16;
  localparam int QueueDepth   = 2;

  // command codes of the input item
  localparam logic [1:0] CmdClear = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdMatch = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [SlotW-1:0] color_slot;
    logic [SlotW-1:0] shade_slot;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
  } ncm_in_t;

  typedef struct packed {
    logic [IndexW-1:0] match_color;
    logic [IndexW-1:0] match_shade;
    logic [DistW-1:0]  best_distance_sq;
  } ncm_out_t;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_WRITE,
    OP_MATCH,
    OP_BLANK
  } op_kind_t;

  // one queued operation; rgba packs r in 7..0, g 15..8, b 23..16, a 31..24
  typedef struct packed {
    op_kind_t          kind;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] rgba;
  } ncm_op_t;

endpackage

[design/ncm_ram.sv]
// ncm_ram: generic single-write, single-read ram with registered read data
// no dependencies

module ncm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/ncm_front.sv]
// ncm_front: accepts input items and turns them into queued operations
// depends on ncm_pkg

module ncm_front import ncm_pkg::*; #(
  parameter int MAX_COLORS = DefMaxColors,
  parameter int MAX_SHADES = DefMaxShades
) (
  input  logic    in_valid,
  output logic    in_ready,
  input  ncm_in_t in_data,
  output logic    push_valid,
  input  logic    push_ready,
  output ncm_op_t push_op
);

  localparam int UsedColors = (MAX_COLORS > SlotLimit) ? SlotLimit : MAX_COLORS;
  localparam int UsedShades = (MAX_SHADES > SlotLimit) ? SlotLimit : MAX_SHADES;

  logic in_range;
  logic keep;

  assign in_ready = push_ready;
  assign in_range = ({1'b0, in_data.color_slot} < (SlotW+1)'(UsedColors)) &&
                    ({1'b0, in_data.shade_slot} < (SlotW+1)'(UsedShades));

  always_comb begin
    keep         = 1'b0;
    push_op.kind = OP_CLEAR;
    push_op.addr = {in_data.color_slot, in_data.shade_slot};
    push_op.rgba = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
    case (in_data.command)
      CmdClear: begin
        keep         = 1'b1;
        push_op.kind = OP_CLEAR;
      end
      CmdWrite: begin
        // writes beyond the configured slots are dropped
        keep         = in_range;
        push_op.kind = OP_WRITE;
      end
      CmdMatch: begin
        keep         = 1'b1;
        push_op.kind = (in_data.alpha == 8'd0) ? OP_BLANK : OP_MATCH;
      end
      default: begin
        keep         = 1'b0;
        push_op.kind = OP_CLEAR;
      end
    endcase
  end

  assign push_valid = in_valid && keep;

endmodule

[design/ncm_queue.sv]
// ncm_queue: short fifo of operations between front and back
// depends on ncm_pkg

module ncm_queue import ncm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  ncm_op_t push_op,
  output logic    pop_valid,
  input  logic    pop_ready,
  output ncm_op_t pop_op
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ncm_op_t         mem_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != CntW'(QueueDepth));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

[design/ncm_back.sv]
// ncm_back: palette storage, valid marks and the sequential nearest-entry search
// depends on ncm_pkg and ncm_ram

module ncm_back import ncm_pkg::*; #(
  parameter int MAX_COLORS = DefMaxColors,
  parameter int MAX_SHADES = DefMaxShades
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     op_valid,
  output logic     op_ready,
  input  ncm_op_t  op,
  output logic     out_valid,
  input  logic     out_ready,
  output ncm_out_t out_data
);

  localparam int UsedColors = (MAX_COLORS > SlotLimit) ? SlotLimit : MAX_COLORS;
  localparam int UsedShades = (MAX_SHADES > SlotLimit) ? SlotLimit : MAX_SHADES;
  localparam logic [SlotW-1:0] LastColor = SlotW'(UsedColors - 1);
  localparam logic [SlotW-1:0] LastShade = SlotW'(UsedShades - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t            state_r;
  logic [SlotW-1:0]  c_r;
  logic [SlotW-1:0]  s_r;
  logic [EntryW-1:0] pix_r;
  logic [TableDepth-1:0] valid_r;

  logic              p1_hit_r;
  logic              p1_last_r;
  logic [SlotW-1:0]  p1_c_r;
  logic [SlotW-1:0]  p1_s_r;
  logic              p2_hit_r;
  logic              p2_last_r;
  logic [SlotW-1:0]  p2_c_r;
  logic [SlotW-1:0]  p2_s_r;
  logic [15:0]       sq_r   [4];
  logic [15:0]       sq_nxt [4];

  logic              found_r;
  logic [IndexW-1:0] best_c_r;
  logic [IndexW-1:0] best_s_r;
  logic [DistW-1:0]  best_d_r;
  logic              out_valid_r;
  ncm_out_t          out_data_r;

  logic              issue;
  logic              last_slot;
  logic              wr_en;
  logic [AddrW-1:0]  rd_addr;
  logic [EntryW-1:0] rd_data;
  logic [DistW-1:0]  sum;
  logic              better;

  assign op_ready  = (state_r == ST_IDLE);
  assign issue     = (state_r == ST_SWEEP);
  assign last_slot = (c_r == LastColor) && (s_r == LastShade);
  assign rd_addr   = {c_r, s_r};
  assign wr_en     = op_valid && op_ready && (op.kind == OP_WRITE);

  ncm_ram #(
    .WIDTH(EntryW),
    .DEPTH(TableDepth)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(op.addr),
    .wr_data(op.rgba),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // per-channel absolute difference squared
  always_comb begin
    logic [7:0] ea;
    logic [7:0] pa;
    logic [7:0] diff;
    for (int i = 0; i < 4; i++) begin
      ea        = rd_data[8*i +: 8];
      pa        = pix_r[8*i +: 8];
      diff      = (ea > pa) ? ea - pa : pa - ea;
      sq_nxt[i] = {8'd0, diff} * {8'd0, diff};
    end
  end

  assign sum    = DistW'(sq_r[0]) + DistW'(sq_r[1]) + DistW'(sq_r[2]) + DistW'(sq_r[3]);
  assign better = p2_hit_r && (!found_r || (sum < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      p1_hit_r    <= 1'b0;
      p1_last_r   <= 1'b0;
      p2_hit_r    <= 1'b0;
      p2_last_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // search pipeline: address, ram read, squares, sum and compare
      p1_hit_r  <= issue && valid_r[rd_addr];
      p1_last_r <= issue && last_slot;
      p1_c_r    <= c_r;
      p1_s_r    <= s_r;
      p2_hit_r  <= p1_hit_r;
      p2_last_r <= p1_last_r;
      p2_c_r    <= p1_c_r;
      p2_s_r    <= p1_s_r;
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= sq_nxt[i];
      end

      if (better) begin
        found_r  <= 1'b1;
        best_d_r <= sum;
        best_c_r <= IndexW'(p2_c_r) + IndexW'(1);
        best_s_r <= IndexW'(p2_s_r) + IndexW'(1);
      end

      // a new result can replace the one taken in the same cycle
      if ((state_r == ST_FINISH) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (op_valid) begin
            case (op.kind)
              OP_CLEAR: begin
                valid_r <= '0;
              end
              OP_WRITE: begin
                valid_r[op.addr] <= 1'b1;
              end
              OP_MATCH: begin
                pix_r    <= op.rgba;
                c_r      <= '0;
                s_r      <= '0;
                found_r  <= 1'b0;
                best_c_r <= '0;
                best_s_r <= '0;
                best_d_r <= '0;
                state_r  <= ST_SWEEP;
              end
              OP_BLANK: begin
                found_r  <= 1'b0;
                best_c_r <= '0;
                best_s_r <= '0;
                best_d_r <= '0;
                state_r  <= ST_FINISH;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (last_slot) begin
            state_r <= ST_DRAIN;
          end else if (s_r == LastShade) begin
            s_r <= '0;
            c_r <= c_r + SlotW'(1);
          end else begin
            s_r <= s_r + SlotW'(1);
          end
        end
        ST_DRAIN: begin
          if (p2_last_r) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.match_color      <= best_c_r;
            out_data_r.match_shade      <= best_s_r;
            out_data_r.best_distance_sq <= best_d_r;
            state_r                     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/nearest_palette_color_match_unit.sv]
// nearest palette color match unit: classify rgba pixels against a 16 x 16 palette
// operation: clears and writes act once the back end is free and takes them; a search
//   walks the capped MAX_COLORS x MAX_SHADES slots one per cycle, then drains its pipeline
// flow: the back end takes no new operation until a search or a transparent pixel is done;
//   a 2-deep queue keeps input flowing; a stalled output holds the last step
// reset: rst_n synchronous, active low; clears all valid marks, queue and output

module nearest_palette_color_match_unit import ncm_pkg::*; #(
  parameter int MAX_COLORS = DefMaxColors,
  parameter int MAX_SHADES = DefMaxShades
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ncm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ncm_out_t out_data
);

  // front to queue
  logic    push_valid;
  logic    push_ready;
  ncm_op_t push_op;

  // queue to back
  logic    pop_valid;
  logic    pop_ready;
  ncm_op_t pop_op;

  // front end: decodes the command, drops unused codes and out-of-range writes,
  // marks alpha-zero pixels so the back end skips the search
  ncm_front #(
    .MAX_COLORS(MAX_COLORS),
    .MAX_SHADES(MAX_SHADES)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op)
  );

  // decoupling queue, keeps item order between the two halves
  ncm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_op   (push_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op)
  );

  // back end: palette ram, valid marks, distance pipeline and output register
  ncm_back #(
    .MAX_COLORS(MAX_COLORS),
    .MAX_SHADES(MAX_SHADES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (pop_valid),
    .op_ready (pop_ready),
    .op       (pop_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
